// ===== rtl/fra_pkg.sv =====
// Package for the fraction arithmetic reduce block: widths, command codes,
// transaction payload types and sequencer states.
// No dependencies.
package fra_pkg;

  localparam int OP_BITS  = 16;
  localparam int NUM_BITS = 2 * OP_BITS + 1;
  localparam int DEN_BITS = 2 * OP_BITS;
  localparam int MAG_BITS = 2 * OP_BITS;
  localparam int CNT_BITS = $clog2(MAG_BITS);
  localparam int NUM_PRODS = 4;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } fra_cmd_e;

  typedef struct packed {
    fra_cmd_e                   command;
    logic signed [OP_BITS-1:0]  left_num;
    logic signed [OP_BITS-1:0]  left_den;
    logic signed [OP_BITS-1:0]  right_num;
    logic signed [OP_BITS-1:0]  right_den;
  } fra_in_t;

  typedef struct packed {
    logic signed [NUM_BITS-1:0] result_num;
    logic signed [DEN_BITS-1:0] result_den;
  } fra_out_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_FORM = 7'b0000100,
    S_MAG  = 7'b0001000,
    S_GCD  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } fra_state_e;

  localparam logic [1:0] PROD_LN_RD = 2'd0;
  localparam logic [1:0] PROD_LD_RN = 2'd1;
  localparam logic [1:0] PROD_LN_RN = 2'd2;
  localparam logic [1:0] PROD_LD_RD = 2'd3;

endpackage

// ===== rtl/fra_mul.sv =====
// Registered signed operand multiplier, shared by all four products.
// Depends on fra_pkg.
module fra_mul import fra_pkg::*; (
  input  logic                       clk_i,
  input  logic signed [OP_BITS-1:0]  a_i,
  input  logic signed [OP_BITS-1:0]  b_i,
  output logic signed [DEN_BITS-1:0] p_o
);

  logic signed [DEN_BITS-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== rtl/fra_sub.sv =====
// Shared subtract and compare unit for the GCD loop and the restoring divider.
// Depends on fra_pkg.
module fra_sub import fra_pkg::*; (
  input  logic [MAG_BITS:0] x_i,
  input  logic [MAG_BITS:0] y_i,
  output logic [MAG_BITS:0] diff_o,
  output logic              borrow_o
);

  assign {borrow_o, diff_o} = {1'b0, x_i} - {1'b0, y_i};

endmodule

// ===== rtl/fraction_arith_reduce.sv =====
// A zero numerator skips the binary GCD loop and the bit-serial divider.
// Throughput: one transaction at a time; the GCD loop and the bit-serial
// divider share one subtractor.
// Reset: asynchronous, active low; clears the sequencer and output valid.
module fraction_arith_reduce import fra_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fra_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output fra_out_t out_data_o
);

  fra_state_e state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  fra_cmd_e cmd_q, cmd_d;
  logic signed [OP_BITS-1:0] ln_q, ln_d, ld_q, ld_d, rn_q, rn_d, rd_q, rd_d;
  logic signed [DEN_BITS-1:0] prod_q [NUM_PRODS];
  logic signed [NUM_BITS-1:0] num_q, num_d;
  logic signed [DEN_BITS-1:0] den_q, den_d;
  logic [MAG_BITS-1:0] a_q, a_d, b_q, b_d, nm_q, nm_d, dm_q, dm_d, rem_q, rem_d;
  logic sn_q, sn_d, sd_q, sd_d, div_den_q, div_den_d;
  logic out_valid_q, out_valid_d;
  fra_out_t out_q, out_d;

  logic signed [OP_BITS-1:0] mul_a, mul_b;
  logic signed [DEN_BITS-1:0] mul_p;
  logic [MAG_BITS:0] sub_x, sub_y, sub_diff;
  logic sub_borrow;
  logic [MAG_BITS-1:0] div_cur;
  logic [MAG_BITS:0] div_trial;
  logic [NUM_BITS-1:0] num_abs;
  logic [DEN_BITS-1:0] den_abs;
  logic out_free;

  fra_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  fra_sub u_sub (
    .x_i      (sub_x),
    .y_i      (sub_y),
    .diff_o   (sub_diff),
    .borrow_o (sub_borrow)
  );

  always_comb begin
    case (cnt_q[1:0])
      PROD_LN_RD: begin mul_a = ln_q; mul_b = rd_q; end
      PROD_LD_RN: begin mul_a = ld_q; mul_b = rn_q; end
      PROD_LN_RN: begin mul_a = ln_q; mul_b = rn_q; end
      default:    begin mul_a = ld_q; mul_b = rd_q; end
    endcase
  end

  assign div_cur   = div_den_q ? dm_q : nm_q;
  assign div_trial = {rem_q, div_cur[MAG_BITS-1]};
  assign sub_x     = (state_q == S_DIV) ? div_trial : {1'b0, a_q};
  assign sub_y     = (state_q == S_DIV) ? {1'b0, a_q} : {1'b0, b_q};
  assign num_abs   = num_q[NUM_BITS-1] ? -num_q : num_q;
  assign den_abs   = den_q[DEN_BITS-1] ? -den_q : den_q;
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    ln_d        = ln_q;
    ld_d        = ld_q;
    rn_d        = rn_q;
    rd_d        = rd_q;
    num_d       = num_q;
    den_d       = den_q;
    a_d         = a_q;
    b_d         = b_q;
    nm_d        = nm_q;
    dm_d        = dm_q;
    rem_d       = rem_q;
    sn_d        = sn_q;
    sd_d        = sd_q;
    div_den_d   = div_den_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_data_i.command;
          ln_d    = in_data_i.left_num;
          rn_d    = in_data_i.right_num;
          ld_d    = (in_data_i.left_den == '0) ? OP_BITS'(1) : in_data_i.left_den;
          rd_d    = (in_data_i.right_den == '0) ? OP_BITS'(1) : in_data_i.right_den;
          cnt_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cnt_d = cnt_q + CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(NUM_PRODS)) begin
          state_d = S_FORM;
        end
      end
      S_FORM: begin
        case (cmd_q)
          CMD_ADD: begin
            num_d = NUM_BITS'(prod_q[0]) + NUM_BITS'(prod_q[1]);
            den_d = prod_q[3];
          end
          CMD_SUB: begin
            num_d = NUM_BITS'(prod_q[0]) - NUM_BITS'(prod_q[1]);
            den_d = prod_q[3];
          end
          CMD_MUL: begin
            num_d = NUM_BITS'(prod_q[2]);
            den_d = prod_q[3];
          end
          default: begin
            num_d = NUM_BITS'(prod_q[0]);
            den_d = prod_q[1];
          end
        endcase
        if (den_d == '0) begin
          den_d = DEN_BITS'(1);
        end
        state_d = S_MAG;
      end
      S_MAG: begin
        if (num_q == '0) begin
          nm_d    = '0;
          dm_d    = MAG_BITS'(1);
          sn_d    = 1'b0;
          sd_d    = 1'b0;
          state_d = S_DONE;
        end else begin
          nm_d    = num_abs[MAG_BITS-1:0];
          dm_d    = den_abs;
          a_d     = num_abs[MAG_BITS-1:0];
          b_d     = den_abs;
          sn_d    = num_q[NUM_BITS-1];
          sd_d    = den_q[DEN_BITS-1];
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        if (a_q == b_q) begin
          cnt_d     = '0;
          rem_d     = '0;
          div_den_d = 1'b0;
          state_d   = S_DIV;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d  = a_q >> 1;
          b_d  = b_q >> 1;
          nm_d = nm_q >> 1;
          dm_d = dm_q >> 1;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (sub_borrow) begin
          a_d = b_q;
          b_d = a_q;
        end else begin
          a_d = sub_diff[MAG_BITS-1:0];
        end
      end
      S_DIV: begin
        rem_d = sub_borrow ? div_trial[MAG_BITS-1:0] : sub_diff[MAG_BITS-1:0];
        if (div_den_q) begin
          dm_d = {dm_q[MAG_BITS-2:0], !sub_borrow};
        end else begin
          nm_d = {nm_q[MAG_BITS-2:0], !sub_borrow};
        end
        cnt_d = cnt_q + CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(MAG_BITS - 1)) begin
          cnt_d = '0;
          rem_d = '0;
          if (div_den_q) begin
            state_d = S_DONE;
          end else begin
            div_den_d = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_d.result_num = sn_q ? -{1'b0, nm_q} : {1'b0, nm_q};
          out_d.result_den = sd_q ? -dm_q : dm_q;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      div_den_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      div_den_q   <= div_den_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    ln_q  <= ln_d;
    ld_q  <= ld_d;
    rn_q  <= rn_d;
    rd_q  <= rd_d;
    num_q <= num_d;
    den_q <= den_d;
    a_q   <= a_d;
    b_q   <= b_d;
    nm_q  <= nm_d;
    dm_q  <= dm_d;
    rem_q <= rem_d;
    sn_q  <= sn_d;
    sd_q  <= sd_d;
    out_q <= out_d;
    if (state_q == S_MUL && cnt_q != '0) begin
      prod_q[2'(cnt_q - CNT_BITS'(1))] <= mul_p;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/fra_checker.sv =====
// Port-level checker for fraction_arith_reduce, attached by bind.
// Depends on fra_pkg.
module fra_port_checker import fra_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input fra_in_t  in_data_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input fra_out_t out_data_i
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready stayed high after a transaction was taken");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.result_den != '0)
    else $error("zero result denominator");

  a_zero_num_unit_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.result_num == '0 |-> out_data_i.result_den == DEN_BITS'(1))
    else $error("zero numerator without unit denominator");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output dropped or changed while stalled");

endmodule

bind fraction_arith_reduce fra_port_checker u_fra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

// ===== dv/fra_checker.sv =====
// Checker for the fraction arithmetic reduce block: watches both channels,
// predicts each reduced fraction and compares it with the block's output.
// Depends on fra_pkg for the payload types and command codes.
module fra_checker import fra_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  fra_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  fra_out_t out_data_i,
  output int       errors_o,
  output int       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  fra_out_t reduced_q[$];
  int       mismatches = 0;

  assign errors_o = mismatches;

  function automatic fra_out_t reduce_fraction(fra_in_t t);
    longint          ln, ld, rn, rd, num, den;
    longint unsigned a, b, r;
    fra_out_t        res;
    ln = t.left_num;
    ld = t.left_den;
    rn = t.right_num;
    rd = t.right_den;
    if (ld == 0) ld = 1;
    if (rd == 0) rd = 1;
    case (t.command)
      CMD_ADD: begin
        num = ln * rd + ld * rn;
        den = ld * rd;
      end
      CMD_SUB: begin
        num = ln * rd - ld * rn;
        den = ld * rd;
      end
      CMD_MUL: begin
        num = ln * rn;
        den = ld * rd;
      end
      default: begin
        num = ln * rd;
        den = ld * rn;
      end
    endcase
    if (den == 0) den = 1;
    if (num == 0) begin
      den = 1;
    end else begin
      a = (num < 0) ? -num : num;
      b = (den < 0) ? -den : den;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      num = num / longint'(a);
      den = den / longint'(a);
    end
    res.result_num = num[NUM_BITS-1:0];
    res.result_den = den[DEN_BITS-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    fra_out_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (reduced_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d/%0d",
                                    out_data_i.result_num, out_data_i.result_den));
        end else begin
          want = reduced_q.pop_front();
          if (out_data_i.result_num !== want.result_num)
            report_mismatch($sformatf("result_num %0d, predicted %0d",
                                      out_data_i.result_num, want.result_num));
          if (out_data_i.result_den !== want.result_den)
            report_mismatch($sformatf("result_den %0d, predicted %0d",
                                      out_data_i.result_den, want.result_den));
        end
      end
      if (in_valid_i && in_ready_i) reduced_q.push_back(reduce_fraction(in_data_i));
      pending_o <= reduced_q.size();
    end
  end

endmodule

// ===== dv/tb_fraction_arith_reduce.sv =====
// Testbench top for fraction_arith_reduce: drives directed and random fraction
// transactions with random idling on both channels and gives the verdict.
// Depends on fra_pkg, fraction_arith_reduce and fra_checker.
module tb_fraction_arith_reduce import fra_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM  = 1030;
  localparam int QUIET_TAIL  = 100;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 250;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  fra_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  fra_out_t out_data_o;

  int n_errors;
  int n_pending;
  int idle_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  fraction_arith_reduce u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  fra_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_i (out_data_o),
    .errors_o   (n_errors),
    .pending_o  (n_pending)
  );

  // hold ready low in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      stall_left <= $urandom_range(5, 0);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_fraction(input fra_cmd_e cmd, input logic [15:0] ln,
                               input logic [15:0] ld, input logic [15:0] rn,
                               input logic [15:0] rd);
    fra_in_t t;
    logic    taken;
    t.command   = cmd;
    t.left_num  = ln;
    t.left_den  = ld;
    t.right_num = rn;
    t.right_den = rd;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(5))
      0, 1: return 16'($urandom_range(65535));
      2:    return 16'($urandom_range(40) - 20);
      3:    return 16'($urandom_range(255));
      4: begin
        case ($urandom_range(4))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'hffff;
          3: return 16'h7fff;
          default: return 16'h8000;
        endcase
      end
      default: return 16'($urandom_range(2000) - 1000);
    endcase
  endfunction

  initial begin
    fra_cmd_e    cmd;
    logic [15:0] ln, ld, rn, rd;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct <= 30;
    send_fraction(CMD_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send_fraction(CMD_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
    send_fraction(CMD_MUL, 16'd6, 16'd4, 16'd2, 16'd3);
    send_fraction(CMD_DIV, 16'd3, 16'd4, 16'd9, 16'd8);
    send_fraction(CMD_ADD, 16'd5, 16'd0, 16'd7, 16'd0);
    send_fraction(CMD_DIV, 16'd3, 16'd4, 16'd0, 16'd5);
    send_fraction(CMD_DIV, 16'd0, 16'd0, 16'd0, 16'd0);
    send_fraction(CMD_MUL, 16'd0, 16'd7, 16'h8000, 16'h7fff);
    send_fraction(CMD_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_fraction(CMD_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_fraction(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
    send_fraction(CMD_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_fraction(CMD_ADD, 16'd1, 16'hfffe, 16'd1, 16'hfffd);
    send_fraction(CMD_SUB, 16'hffff, 16'hffff, 16'hffff, 16'd1);
    send_fraction(CMD_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_fraction(CMD_DIV, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_fraction(CMD_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_fraction(CMD_SUB, 16'h7fff, 16'd0, 16'h8000, 16'd0);
    send_fraction(CMD_DIV, 16'h8000, 16'd1, 16'd0, 16'h8000);
    send_fraction(CMD_ADD, 16'd12, 16'hfff8, 16'hfffa, 16'd4);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - QUIET_TAIL) idle_pct <= 0;
      else if (i < NUM_RANDOM - QUIET_TAIL && i % 64 == 0) begin
        case ($urandom_range(2))
          0: idle_pct <= 0;
          1: idle_pct <= 20;
          default: idle_pct <= 60;
        endcase
      end
      cmd = fra_cmd_e'($urandom_range(3));
      ln  = pick_operand();
      ld  = pick_operand();
      rn  = pick_operand();
      rd  = pick_operand();
      if ($urandom_range(15) == 0) begin
        rn = -ln;
        rd = ld;
      end
      send_fraction(cmd, ln, ld, rn, rd);
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (n_pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fra_pkg.sv
rtl/fra_mul.sv
rtl/fra_sub.sv
rtl/fraction_arith_reduce.sv
rtl/fra_checker.sv
dv/fra_checker.sv
dv/tb_fraction_arith_reduce.sv
